// File: src/bfsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfsd_pkg
// Shared types and constants of the boiler frame sensor decoder.
// ----------------------------------------------------------------------------
package bfsd_pkg;

  localparam int NUM_ENTRIES = 10;
  localparam int MAX_FRAME   = 512;
  localparam int POS_W       = $clog2(MAX_FRAME);

  localparam int BYTE_W      = 8;
  localparam int IDX_W       = 4;
  localparam int VAL_W       = 15;
  localparam int ID_W        = 24;
  localparam int RAW_W       = 16;
  localparam int REC_W       = 32;

  localparam int NUM_PAIRS   = 5;
  localparam int PERCENT_REG = 5;
  localparam int CFG_W       = 48;
  localparam int CFG_IDX_W   = 3;
  localparam int PCT_W       = 4;

  localparam int LEN_POS     = 3;
  localparam int REC_START   = 5;
  localparam int REC_LEN     = 5;
  localparam int OFF_W       = $clog2(REC_LEN);

  localparam logic [BYTE_W-1:0] END_BYTE  = 8'h7D;
  localparam logic [RAW_W-1:0]  WRAP_ABOVE = 16'd65000;
  localparam logic [RAW_W-1:0]  VAL_MAX    = 16'd10000;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [CFG_W-1:0] ID_PAIR_RESET [NUM_PAIRS] = '{
    48'd8796278095884,
    48'd8796311650314,
    48'd8797351837766,
    48'd8796227764239,
    48'd8797234397193
  };
  localparam logic [PCT_W-1:0] PERCENT_RESET = 4'd5;

  typedef struct packed {
    logic                    rec;
    logic                    fin;
    logic [ID_W-1:0]         id;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

endpackage

// File: src/bfsd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfsd_front
// Byte counter and record assembler: issues record and frame-end commands.
// ----------------------------------------------------------------------------
module bfsd_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bfsd_pkg::BYTE_W-1:0]  in_rx_byte,
  output logic                         cmd_valid,
  input  logic                         cmd_ready,
  output bfsd_pkg::cmd_t               cmd
);

  localparam int CMP_W = bfsd_pkg::POS_W + bfsd_pkg::BYTE_W;

  logic [bfsd_pkg::POS_W-1:0]  pos_r;
  logic [bfsd_pkg::BYTE_W-1:0] len_r;
  logic                        known_r;
  logic [bfsd_pkg::OFF_W-1:0]  off_r;
  logic [bfsd_pkg::REC_W-1:0]  rec_r;

  logic                        take;
  logic                        at_len;
  logic                        in_body;
  logic                        not_sat;
  logic                        rec_done;
  logic                        fin;
  logic [bfsd_pkg::BYTE_W-1:0] len_eff;
  logic                        known_eff;
  logic [bfsd_pkg::POS_W:0]    count;
  logic [bfsd_pkg::RAW_W-1:0]  raw;
  logic signed [bfsd_pkg::VAL_W-1:0] value;

  always_comb begin
    not_sat   = pos_r < bfsd_pkg::POS_W'(bfsd_pkg::MAX_FRAME - 1);
    at_len    = pos_r == bfsd_pkg::POS_W'(bfsd_pkg::LEN_POS);
    in_body   = (pos_r >= bfsd_pkg::POS_W'(bfsd_pkg::REC_START)) && not_sat;
    rec_done  = in_body && (off_r == bfsd_pkg::OFF_W'(bfsd_pkg::REC_LEN - 1));
    len_eff   = at_len ? in_rx_byte : len_r;
    known_eff = known_r | at_len;
    count     = {1'b0, pos_r} + 1'b1;
    fin       = (in_rx_byte == bfsd_pkg::END_BYTE) && known_eff && (len_eff != '0) &&
                (CMP_W'(count) >= CMP_W'(len_eff));
    raw       = {rec_r[bfsd_pkg::BYTE_W-1:0], in_rx_byte};
    priority if (raw > bfsd_pkg::WRAP_ABOVE) begin
      value = raw[bfsd_pkg::VAL_W-1:0];
    end else if (raw > bfsd_pkg::VAL_MAX) begin
      value = '0;
    end else begin
      value = raw[bfsd_pkg::VAL_W-1:0];
    end
  end

  assign in_ready   = cmd_ready;
  assign take       = in_valid & in_ready;
  assign cmd_valid  = in_valid & (rec_done | fin);
  assign cmd.rec    = rec_done;
  assign cmd.fin    = fin;
  assign cmd.id     = rec_r[bfsd_pkg::REC_W-1:bfsd_pkg::BYTE_W];
  assign cmd.value  = value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      len_r   <= '0;
      known_r <= 1'b0;
      off_r   <= '0;
    end else if (take) begin
      if (at_len) begin
        len_r   <= in_rx_byte;
        known_r <= 1'b1;
      end
      if (pos_r == bfsd_pkg::POS_W'(bfsd_pkg::REC_START - 1)) begin
        off_r <= '0;
      end else if (in_body) begin
        off_r <= rec_done ? '0 : off_r + 1'b1;
      end
      if (fin) begin
        pos_r <= '0;
      end else if (not_sat) begin
        pos_r <= pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_body && !rec_done) begin
      rec_r <= {rec_r[bfsd_pkg::REC_W-bfsd_pkg::BYTE_W-1:0], in_rx_byte};
    end
  end

endmodule

// File: src/bfsd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfsd_queue
// Short command queue between the byte front and the table back.
// ----------------------------------------------------------------------------
module bfsd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  bfsd_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output bfsd_pkg::cmd_t pop_cmd
);

  bfsd_pkg::cmd_t                  mem_r [bfsd_pkg::Q_DEPTH];
  logic [bfsd_pkg::Q_PTR_W-1:0]    wr_r;
  logic [bfsd_pkg::Q_PTR_W-1:0]    rd_r;
  logic [bfsd_pkg::Q_CNT_W-1:0]    cnt_r;
  logic                            do_push;
  logic                            do_pop;

  assign push_ready = cnt_r != bfsd_pkg::Q_CNT_W'(bfsd_pkg::Q_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_cmd    = mem_r[rd_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == bfsd_pkg::Q_PTR_W'(bfsd_pkg::Q_DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= (rd_r == bfsd_pkg::Q_PTR_W'(bfsd_pkg::Q_DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

endmodule

// File: src/bfsd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfsd_back
// Id table, entry store and frame-end drain into the output register.
// ----------------------------------------------------------------------------
module bfsd_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bfsd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bfsd_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                cmd_valid,
  output logic                                cmd_ready,
  input  bfsd_pkg::cmd_t                      cmd,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bfsd_pkg::IDX_W-1:0]          out_entry_index,
  output logic signed [bfsd_pkg::VAL_W-1:0]   out_sensor_value,
  output logic                                out_is_percent,
  output logic                                out_last_of_frame
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic [bfsd_pkg::CFG_W-1:0]        pair_r  [bfsd_pkg::NUM_PAIRS];
  logic [bfsd_pkg::PCT_W-1:0]        pct_r;
  logic signed [bfsd_pkg::VAL_W-1:0] value_r [bfsd_pkg::NUM_ENTRIES];
  logic [bfsd_pkg::NUM_ENTRIES-1:0]  valid_r;
  logic                              state_r;

  logic                              out_valid_r;
  logic [bfsd_pkg::IDX_W-1:0]        out_idx_r;
  logic signed [bfsd_pkg::VAL_W-1:0] out_val_r;
  logic                              out_pct_r;
  logic                              out_last_r;

  logic [bfsd_pkg::NUM_ENTRIES-1:0]  match;
  logic [bfsd_pkg::NUM_ENTRIES-1:0]  low_hot;
  logic [bfsd_pkg::IDX_W-1:0]        low_idx;
  logic                              take;
  logic                              load;
  logic [bfsd_pkg::ID_W-1:0]         ent_id;

  assign cmd_ready = state_r == ST_IDLE;
  assign take      = cmd_valid & cmd_ready;
  assign load      = (state_r == ST_DRAIN) && (valid_r != '0) && (!out_valid_r || out_ready);

  always_comb begin
    match = '0;
    for (int e = 0; e < bfsd_pkg::NUM_ENTRIES; e++) begin
      ent_id   = pair_r[e / 2][(e % 2) * bfsd_pkg::ID_W +: bfsd_pkg::ID_W];
      match[e] = ent_id == cmd.id;
    end
  end

  always_comb begin
    low_hot = '0;
    low_idx = '0;
    for (int e = bfsd_pkg::NUM_ENTRIES - 1; e >= 0; e--) begin
      if (valid_r[e]) begin
        low_hot = '0;
        low_hot[e] = 1'b1;
        low_idx = bfsd_pkg::IDX_W'(e);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < bfsd_pkg::NUM_PAIRS; k++) begin
        pair_r[k] <= bfsd_pkg::ID_PAIR_RESET[k];
      end
      pct_r <= bfsd_pkg::PERCENT_RESET;
    end else if (cfg_we) begin
      for (int k = 0; k < bfsd_pkg::NUM_PAIRS; k++) begin
        if (cfg_index == bfsd_pkg::CFG_IDX_W'(k)) begin
          pair_r[k] <= cfg_data;
        end
      end
      if (cfg_index == bfsd_pkg::CFG_IDX_W'(bfsd_pkg::PERCENT_REG)) begin
        pct_r <= cfg_data[bfsd_pkg::PCT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (take) begin
            if (cmd.rec) begin
              valid_r <= valid_r | match;
            end
            if (cmd.fin) begin
              state_r <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (valid_r == '0) begin
            state_r <= ST_IDLE;
          end else if (load) begin
            valid_r     <= valid_r & ~low_hot;
            out_valid_r <= 1'b1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take && cmd.rec) begin
      for (int e = 0; e < bfsd_pkg::NUM_ENTRIES; e++) begin
        if (match[e]) begin
          value_r[e] <= cmd.value;
        end
      end
    end
    if (load) begin
      out_idx_r  <= low_idx;
      out_val_r  <= value_r[low_idx];
      out_pct_r  <= low_idx == pct_r;
      out_last_r <= (valid_r & ~low_hot) == '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_entry_index   = out_idx_r;
  assign out_sensor_value  = out_val_r;
  assign out_is_percent    = out_pct_r;
  assign out_last_of_frame = out_last_r;

endmodule

// File: src/boiler_frame_sensor_decoder.sv
// Output: a frame-end item passes through the command queue and the drain state into
//   the output register; a frame's results follow one per cycle while out_ready holds.
// Throughput: one item per cycle while the two-entry command queue has room; the
//   back end takes one command at a time and accepts none while it drains a frame.
// Reset: synchronous, active low; ids and percent entry return to defaults, counters,
//   queue and all entry match flags clear.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boiler_frame_sensor_decoder
// Decodes sensor records of heating-controller frames and reports them per entry.
// ----------------------------------------------------------------------------
module boiler_frame_sensor_decoder (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bfsd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bfsd_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bfsd_pkg::BYTE_W-1:0]         in_rx_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bfsd_pkg::IDX_W-1:0]          out_entry_index,
  output logic signed [bfsd_pkg::VAL_W-1:0]   out_sensor_value,
  output logic                                out_is_percent,
  output logic                                out_last_of_frame
);

  logic           f_valid;
  logic           f_ready;
  bfsd_pkg::cmd_t f_cmd;
  logic           b_valid;
  logic           b_ready;
  bfsd_pkg::cmd_t b_cmd;

  bfsd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .cmd_valid  (f_valid),
    .cmd_ready  (f_ready),
    .cmd        (f_cmd)
  );

  bfsd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_cmd    (b_cmd)
  );

  bfsd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .cmd_valid         (b_valid),
    .cmd_ready         (b_ready),
    .cmd               (b_cmd),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_entry_index   (out_entry_index),
    .out_sensor_value  (out_sensor_value),
    .out_is_percent    (out_is_percent),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule

// File: dv/boiler_frame_sensor_decoder_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boiler_frame_sensor_decoder_chk
// Watches the byte, result and register ports of the sensor decoder. It keeps
// its own frame parser and entry table, queues the per-entry reports that each
// frame end should produce, and compares every accepted result against them.
// ----------------------------------------------------------------------------
module boiler_frame_sensor_decoder_chk (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bfsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bfsd_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [bfsd_pkg::BYTE_W-1:0]       in_rx_byte,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [bfsd_pkg::IDX_W-1:0]        out_entry_index,
  input  logic signed [bfsd_pkg::VAL_W-1:0] out_sensor_value,
  input  logic                              out_is_percent,
  input  logic                              out_last_of_frame,
  output int                                fail_count,
  output int                                reports_waiting
);
  import bfsd_pkg::*;

  localparam int WRAP_LIMIT = 65000;
  localparam int WRAP_SPAN  = 65536;
  localparam int LOW_LIMIT  = -1000;
  localparam int HIGH_LIMIT = 10000;

  typedef struct packed {
    logic [IDX_W-1:0]        entry;
    logic signed [VAL_W-1:0] value;
    logic                    percent;
    logic                    last;
  } sensor_report_t;

  sensor_report_t          reports_due [$];
  logic [CFG_W-1:0]        id_pairs [NUM_PAIRS];
  logic [PCT_W-1:0]        percent_sel;
  logic [POS_W-1:0]        frame_pos;
  logic [BYTE_W-1:0]       frame_len;
  logic                    len_seen;
  logic [REC_W-1:0]        rec_shift;
  logic signed [VAL_W-1:0] entry_val [NUM_ENTRIES];
  logic                    entry_hit [NUM_ENTRIES];
  int                      errors = 0;

  function automatic logic [ID_W-1:0] entry_sensor_id(input int e);
    logic [CFG_W-1:0] pair;
    pair = id_pairs[e / 2];
    return (e % 2) ? pair[CFG_W-1:ID_W] : pair[ID_W-1:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] scale_raw(input logic [RAW_W-1:0] raw);
    int v;
    v = raw;
    if (v > WRAP_LIMIT) v = v - WRAP_SPAN;
    if (v < LOW_LIMIT || v > HIGH_LIMIT) v = 0;
    return v[VAL_W-1:0];
  endfunction

  task automatic clear_parser();
    int e;
    for (e = 0; e < NUM_PAIRS; e++) id_pairs[e] = ID_PAIR_RESET[e];
    percent_sel = PERCENT_RESET;
    frame_pos   = '0;
    frame_len   = '0;
    len_seen    = 1'b0;
    rec_shift   = '0;
    for (e = 0; e < NUM_ENTRIES; e++) entry_hit[e] = 1'b0;
    reports_due.delete();
  endtask

  task automatic absorb_byte(input logic [BYTE_W-1:0] b);
    int             p;
    int             e;
    int             last_hit;
    logic [ID_W-1:0]  rid;
    logic [RAW_W-1:0] raw;
    sensor_report_t   r;
    p = frame_pos;
    if (p == LEN_POS) begin
      frame_len = b;
      len_seen  = 1'b1;
    end
    if (p >= REC_START && p < MAX_FRAME - 1) begin
      if ((p - REC_START) % REC_LEN < REC_LEN - 1) begin
        rec_shift = {rec_shift[REC_W-BYTE_W-1:0], b};
      end else begin
        rid = rec_shift[REC_W-1:BYTE_W];
        raw = {rec_shift[BYTE_W-1:0], b};
        for (e = 0; e < NUM_ENTRIES; e++) begin
          if (entry_sensor_id(e) == rid) begin
            entry_val[e] = scale_raw(raw);
            entry_hit[e] = 1'b1;
          end
        end
      end
    end
    if (p < MAX_FRAME - 1) frame_pos = POS_W'(p + 1);
    if (b == END_BYTE && len_seen && frame_len != 0 && p + 1 >= frame_len) begin
      last_hit = -1;
      for (e = 0; e < NUM_ENTRIES; e++) if (entry_hit[e]) last_hit = e;
      for (e = 0; e < NUM_ENTRIES; e++) begin
        if (entry_hit[e]) begin
          r.entry   = IDX_W'(e);
          r.value   = entry_val[e];
          r.percent = (e == percent_sel);
          r.last    = (e == last_hit);
          reports_due.push_back(r);
          entry_hit[e] = 1'b0;
        end
      end
      frame_pos = '0;
      rec_shift = '0;
    end
  endtask

  task automatic match_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    sensor_report_t due;
    if (!rst_n) begin
      clear_parser();
    end else begin
      if (cfg_we) begin
        if (cfg_index < NUM_PAIRS) id_pairs[cfg_index] = cfg_data;
        else if (cfg_index == PERCENT_REG) percent_sel = cfg_data[PCT_W-1:0];
      end
      if (out_valid && out_ready) begin
        if (reports_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result expected none actual entry %0d value %0d",
                   $time, out_entry_index, out_sensor_value);
        end else begin
          due = reports_due.pop_front();
          match_field("entry_index", due.entry, out_entry_index);
          match_field("sensor_value", $signed(due.value), out_sensor_value);
          match_field("is_percent", due.percent, out_is_percent);
          match_field("last_of_frame", due.last, out_last_of_frame);
        end
      end
      if (in_valid && in_ready) absorb_byte(in_rx_byte);
    end
    fail_count      <= errors;
    reports_waiting <= reports_due.size();
  end

endmodule

// File: dv/boiler_frame_sensor_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boiler_frame_sensor_decoder_tb
// Feeds heating-controller frames byte by byte into the sensor decoder: a few
// hand-built frames, then random well-formed and broken frames under three
// idle patterns and three id tables, an overlong frame and a zero-length one.
// ----------------------------------------------------------------------------
module boiler_frame_sensor_decoder_tb;
  import bfsd_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 6;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int OVERLONG_RECS = 103;

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index  = '0;
  logic [CFG_W-1:0]        cfg_data   = '0;
  logic                    in_valid   = 1'b0;
  logic                    in_ready;
  logic [BYTE_W-1:0]       in_rx_byte = '0;
  logic                    out_valid;
  logic                    out_ready  = 1'b0;
  logic [IDX_W-1:0]        out_entry_index;
  logic signed [VAL_W-1:0] out_sensor_value;
  logic                    out_is_percent;
  logic                    out_last_of_frame;

  int                send_idle   = 30;
  int                recv_idle   = 82;
  logic              hold_go     = 1'b0;
  int                hold_count  = 0;
  int                cycle_count = 0;
  int                random_sent = 0;
  int                fail_count;
  int                reports_waiting;
  logic [CFG_W-1:0]  cfg_words [NUM_PAIRS];
  logic [PCT_W-1:0]  pct_word;
  logic [BYTE_W-1:0] frame_buf [$];

  boiler_frame_sensor_decoder u_top (.*);

  boiler_frame_sensor_decoder_chk u_chk (.*);

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("boiler_frame_sensor_decoder_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_go && hold_count < HOLD_CYCLES) begin
      out_ready  <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic logic [ID_W-1:0] table_id(input int e);
    return (e % 2) ? cfg_words[e / 2][CFG_W-1:ID_W] : cfg_words[e / 2][ID_W-1:0];
  endfunction

  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] b;
    b = BYTE_W'($urandom_range(255));
    return (b == END_BYTE) ? END_BYTE - 8'd1 : b;
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    logic [ID_W-1:0] id;
    id = ID_W'($urandom());
    if ($urandom_range(99) < 85) id = table_id($urandom_range(NUM_ENTRIES - 1));
    return id;
  endfunction

  function automatic logic [RAW_W-1:0] pick_raw();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'd10000;
      2:       return 16'd10001;
      3:       return 16'd65000;
      4:       return 16'd65001;
      5:       return 16'hFFFF;
      6:       return RAW_W'($urandom_range(10000));
      7:       return RAW_W'($urandom_range(65535, 65001));
      default: return RAW_W'($urandom_range(65535));
    endcase
  endfunction

  task automatic shuffle_ids();
    int k;
    for (k = 0; k < NUM_PAIRS; k++) begin
      cfg_words[k][CFG_W-1:ID_W] = ID_W'($urandom());
      cfg_words[k][ID_W-1:0]     = ID_W'($urandom());
    end
  endtask

  task automatic apply_config();
    int k;
    for (k = 0; k < NUM_PAIRS; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(k);
      cfg_data  <= cfg_words[k];
      @(posedge clk);
    end
    cfg_index <= CFG_IDX_W'(PERCENT_REG);
    cfg_data  <= CFG_W'(pct_word);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_frame();
    int i;
    for (i = 0; i < frame_buf.size(); i++) send_byte(frame_buf[i]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic frame_begin();
    frame_buf.delete();
    repeat (LEN_POS) frame_buf.push_back(plain_byte());
    frame_buf.push_back('0);
    frame_buf.push_back(BYTE_W'($urandom_range(255)));
  endtask

  task automatic put_record(input logic [ID_W-1:0] id, input logic [RAW_W-1:0] raw,
                            input bit clean);
    logic [ID_W+RAW_W-1:0] rec;
    int                    i;
    rec = {id, raw};
    for (i = REC_LEN - 1; i >= 0; i--) begin
      if (clean && rec[i*BYTE_W +: BYTE_W] == END_BYTE) frame_buf.push_back(END_BYTE + 8'd1);
      else frame_buf.push_back(rec[i*BYTE_W +: BYTE_W]);
    end
  endtask

  // length covers the whole frame, so no earlier end byte can close it
  task automatic frame_end(input int cut);
    repeat (cut) frame_buf.push_back(BYTE_W'($urandom_range(255)));
    frame_buf.push_back(END_BYTE);
    frame_buf[LEN_POS] = BYTE_W'(frame_buf.size());
  endtask

  task automatic build_good_frame(input int recs, input int cut);
    frame_begin();
    repeat (recs) put_record(pick_id(), pick_raw(), 1'b0);
    frame_end(cut);
  endtask

  task automatic run_random(input int target);
    int sel;
    while (random_sent < target) begin
      sel = $urandom_range(99);
      if (sel < 80) begin
        build_good_frame($urandom_range(6), ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0);
      end else if (sel < 82) begin
        build_good_frame($urandom_range(12, 30), 0);
      end else begin
        frame_begin();
        repeat ($urandom_range(1, 40)) frame_buf.push_back(plain_byte());
        frame_buf.push_back(END_BYTE);
        frame_buf[LEN_POS] = BYTE_W'($urandom_range(1, frame_buf.size()));
      end
      random_sent += frame_buf.size();
      send_frame();
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    shuffle_ids();
    cfg_words[1][CFG_W-1:ID_W] = cfg_words[1][ID_W-1:0];
    pct_word = '0;
    apply_config();

    // end bytes before any length is known
    frame_buf.delete();
    repeat (LEN_POS) frame_buf.push_back(END_BYTE);
    frame_buf.push_back('0);
    frame_buf.push_back('0);
    put_record(table_id(0), 16'd10000, 1'b0);
    frame_end(0);
    send_frame();

    // length of one carries over to the next frame start
    frame_begin();
    frame_end(0);
    frame_buf[LEN_POS] = 8'd1;
    frame_buf.push_back(END_BYTE);
    frame_buf.push_back(END_BYTE);
    send_frame();

    frame_begin();
    put_record(table_id(2), 16'd65001, 1'b0);
    put_record(table_id(1), 16'hFFFF, 1'b0);
    put_record(table_id(4), 16'd10001, 1'b0);
    put_record(table_id(4), 16'd10000, 1'b0);
    put_record(table_id(5), 16'd65000, 1'b0);
    put_record(table_id(9), 16'd0, 1'b0);
    put_record(table_id(6), 16'd64536, 1'b0);
    frame_end(2);
    send_frame();

    run_random(60);
    wait_drained();
    run_random(150);

    wait_drained();
    send_idle = 82;
    recv_idle = 30;
    shuffle_ids();
    cfg_words[0] = '0;
    cfg_words[NUM_PAIRS-1] = '1;
    pct_word = '1;
    apply_config();
    run_random(310);

    wait_drained();
    send_idle = 0;
    recv_idle = 0;
    shuffle_ids();
    pct_word = PCT_W'(NUM_ENTRIES - 1);
    apply_config();
    hold_go <= 1'b1;
    run_random(470);

    // run past the saturated position before the end byte
    frame_begin();
    repeat (OVERLONG_RECS) put_record(pick_id(), pick_raw(), 1'b1);
    repeat (12) frame_buf.push_back(plain_byte());
    frame_buf.push_back(END_BYTE);
    frame_buf[LEN_POS] = BYTE_W'($urandom_range(6, 255));
    send_frame();

    // zero length: nothing closes this frame
    frame_begin();
    put_record(table_id(0), pick_raw(), 1'b0);
    frame_buf.push_back(END_BYTE);
    frame_buf.push_back(END_BYTE);
    send_frame();

    wait_drained();
    if (fail_count == 0) begin
      $display("boiler_frame_sensor_decoder_tb OK");
    end else begin
      $display("boiler_frame_sensor_decoder_tb NOT OK");
    end
    $finish;
  end

endmodule
